>>> rtl/msudt_pkg.sv
package msudt_pkg;

    // field widths
    localparam int ACTION_W  = 3;
    localparam int MINUTES_W = 7;
    localparam int SECONDS_W = 6;
    localparam int STEPS_W   = 8;
    localparam int PHASE_W   = 4;
    localparam int MODE_W    = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 2;

    // parameter defaults
    localparam int DEF_TICKS_PER_SECOND = 10;
    localparam int DEF_COUNT_WIDTH      = 8;

    localparam logic [MINUTES_W-1:0] MAX_MINUTES    = 7'd99;
    localparam logic [SECONDS_W-1:0] MAX_SECONDS    = 6'd59;
    localparam logic [SECONDS_W-1:0] SECONDS_PER_MIN = 6'd60;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RUN_ENABLE = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENCODER = 3'd0,
        ACT_TICK    = 3'd1,
        ACT_ALARM   = 3'd2,
        ACT_SLEEP   = 3'd3,
        ACT_LOAD    = 3'd4
    } t_action;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLOCK = 2'd0,
        MODE_UP    = 2'd1,
        MODE_DOWN  = 2'd2
    } t_mode;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic                 b_level;
        logic [MINUTES_W-1:0] load_minutes;
        logic [SECONDS_W-1:0] load_seconds;
    } t_item;

    typedef struct packed {
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
        logic [STEPS_W-1:0]   cw_steps;
        logic [STEPS_W-1:0]   ccw_steps;
        logic [PHASE_W-1:0]   phase;
        logic                 led;
        logic                 colon;
        logic                 point;
        logic                 refresh;
        logic                 alarm;
        logic                 sleep;
    } t_result;

endpackage

>>> rtl/msudt_in_stage.sv
module msudt_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  msudt_pkg::t_item     i_item,
    input  logic                 i_advance,
    output logic                 o_valid,
    output msudt_pkg::t_item     o_item
);
    import msudt_pkg::*;

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/msudt_core.sv
module msudt_core #(
    parameter int TICKS_PER_SECOND = msudt_pkg::DEF_TICKS_PER_SECOND,
    parameter int COUNT_WIDTH      = msudt_pkg::DEF_COUNT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msudt_pkg::t_cfg_wr   i_cfg,
    input  logic                 i_fire,
    input  msudt_pkg::t_item     i_item,
    output msudt_pkg::t_result   o_result
);
    import msudt_pkg::*;

    localparam logic [PHASE_W-1:0] TPS = PHASE_W'(TICKS_PER_SECOND);

    logic [MODE_W-1:0]      r_mode;
    logic                   r_run;
    logic [MINUTES_W-1:0]   r_min,   n_min;
    logic [SECONDS_W-1:0]   r_sec,   n_sec;
    logic [COUNT_WIDTH-1:0] r_cw,    n_cw;
    logic [COUNT_WIDTH-1:0] r_ccw,   n_ccw;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic                   r_led,   n_led;
    logic                   r_colon, n_colon;
    logic                   r_point, n_point;
    logic                   r_sleep, n_sleep;
    logic                   refresh;
    logic                   alarm;
    logic [COUNT_WIDTH+STEPS_W-1:0] cw_ext;
    logic [COUNT_WIDTH+STEPS_W-1:0] ccw_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_run  <= 1'b0;
        end else if (i_cfg.wr_en) begin
            if (i_cfg.addr == CFG_TIMER_MODE) begin
                r_mode <= i_cfg.data[MODE_W-1:0];
            end else if (i_cfg.addr == CFG_RUN_ENABLE) begin
                r_run <= i_cfg.data[0];
            end
        end
    end

    always_comb begin
        n_min   = r_min;
        n_sec   = r_sec;
        n_cw    = r_cw;
        n_ccw   = r_ccw;
        n_phase = r_phase;
        n_led   = r_led;
        n_colon = r_colon;
        n_point = r_point;
        n_sleep = r_sleep;
        refresh = 1'b0;
        alarm   = 1'b0;
        unique case (t_action'(i_item.action))
            ACT_ENCODER: begin
                if (!i_item.b_level) begin
                    n_cw  = r_cw + COUNT_WIDTH'(1);
                    n_ccw = '0;
                end else begin
                    n_ccw = r_ccw + COUNT_WIDTH'(1);
                    n_cw  = '0;
                end
            end
            ACT_TICK: begin
                refresh = 1'b1;
                n_phase = r_phase + PHASE_W'(1);
                if (n_phase >= TPS) begin
                    n_phase = '0;
                    n_led   = ~r_led;
                    unique case (t_mode'(r_mode))
                        MODE_CLOCK: n_colon = ~r_colon;
                        MODE_UP: begin
                            n_point = ~r_point;
                            if (r_run) begin
                                n_sec = r_sec + SECONDS_W'(1);
                                if (n_sec >= SECONDS_PER_MIN) begin
                                    n_sec = '0;
                                    n_min = r_min + MINUTES_W'(1);
                                end
                                // 99 minutes rolls over to zero
                                if (n_min >= MAX_MINUTES) begin
                                    n_min = '0;
                                end
                            end
                        end
                        MODE_DOWN: begin
                            n_point = ~r_point;
                            if (r_run && !(r_sec == '0 && r_min == '0)) begin
                                if (r_sec == '0) begin
                                    n_sec = MAX_SECONDS;
                                    n_min = r_min - MINUTES_W'(1);
                                end else begin
                                    n_sec = r_sec - SECONDS_W'(1);
                                end
                            end
                        end
                        default: ; // unused mode: LED only
                    endcase
                end
            end
            ACT_ALARM: alarm = 1'b1;
            ACT_SLEEP: n_sleep = ~r_sleep;
            ACT_LOAD: begin
                n_min = (i_item.load_minutes > MAX_MINUTES) ? MAX_MINUTES
                                                            : i_item.load_minutes;
                n_sec = (i_item.load_seconds > MAX_SECONDS) ? MAX_SECONDS
                                                            : i_item.load_seconds;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_sec   <= '0;
            r_cw    <= '0;
            r_ccw   <= '0;
            r_phase <= '0;
            r_led   <= 1'b0;
            r_colon <= 1'b0;
            r_point <= 1'b0;
            r_sleep <= 1'b0;
        end else if (i_fire) begin
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_cw    <= n_cw;
            r_ccw   <= n_ccw;
            r_phase <= n_phase;
            r_led   <= n_led;
            r_colon <= n_colon;
            r_point <= n_point;
            r_sleep <= n_sleep;
        end
    end

    // low 8 bits of each count, zero-filled for narrow counters
    assign cw_ext  = {{STEPS_W{1'b0}}, n_cw};
    assign ccw_ext = {{STEPS_W{1'b0}}, n_ccw};

    always_comb begin
        o_result.minutes   = n_min;
        o_result.seconds   = n_sec;
        o_result.cw_steps  = cw_ext[STEPS_W-1:0];
        o_result.ccw_steps = ccw_ext[STEPS_W-1:0];
        o_result.phase     = n_phase;
        o_result.led       = n_led;
        o_result.colon     = n_colon;
        o_result.point     = n_point;
        o_result.refresh   = refresh;
        o_result.alarm     = alarm;
        o_result.sleep     = n_sleep;
    end

endmodule

>>> rtl/msudt_out_stage.sv
module msudt_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  msudt_pkg::t_result   i_result,
    input  logic                 i_taken,
    output logic                 o_valid,
    output msudt_pkg::t_result   o_result
);
    import msudt_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/minute_second_up_down_timer.sv
// channel   direction  carries
// s_axis    in         event word: action in tuser, encoder level and load time in tdata
// m_axis    out        state word after the event; tick/alarm flags in tuser
// cfg       in         write-only registers: 0 timer_mode, 1 run_enable
//
// One word per cycle while m_axis_tready is high; input register, then result register.
// All state updates in one pass of small counters between those two registers.
// Reset (synchronous, active low) clears state, registers and both stages.
// A stalled result holds in the result register; the input register still
// takes one more word, then s_axis_tready drops until the result leaves.
module minute_second_up_down_timer #(
    parameter int TICKS_PER_SECOND = msudt_pkg::DEF_TICKS_PER_SECOND,
    parameter int COUNT_WIDTH      = msudt_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] encoder_b_level, [7:1] load_minutes, [13:8] load_seconds
    input  logic [15:0]                      s_axis_tdata,
    // [2:0] action
    input  logic [msudt_pkg::ACTION_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [6:0] minutes_now, [12:7] seconds_now, [20:13] clockwise_steps,
    // [28:21] counter_steps, [32:29] tick_phase, [33] led_on, [34] colon_alt,
    // [35] point_alt, [36] sleep_on
    output logic [39:0]                      m_axis_tdata,
    // [0] display_refresh, [1] alarm_hit
    output logic [1:0]                       m_axis_tuser,
    input  logic                             i_cfg_wr_en,
    input  logic [msudt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [msudt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msudt_pkg::*;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    advance;
    logic    in_load;
    t_cfg_wr cfg_wr;
    t_result core_result;
    t_result out_result;
    logic    out_valid;

    assign in_item.action       = s_axis_tuser;
    assign in_item.b_level      = s_axis_tdata[0];
    assign in_item.load_minutes = s_axis_tdata[7:1];
    assign in_item.load_seconds = s_axis_tdata[13:8];

    assign cfg_wr.wr_en = i_cfg_wr_en;
    assign cfg_wr.addr  = i_cfg_addr;
    assign cfg_wr.data  = i_cfg_data;

    assign advance       = st_valid && (!out_valid || m_axis_tready);
    assign s_axis_tready = !st_valid || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    msudt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_load),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    msudt_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_fire   (advance),
        .i_item   (st_item),
        .o_result (core_result)
    );

    msudt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_taken  (m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {3'b000,
                            out_result.sleep,
                            out_result.point,
                            out_result.colon,
                            out_result.led,
                            out_result.phase,
                            out_result.ccw_steps,
                            out_result.cw_steps,
                            out_result.seconds,
                            out_result.minutes};
    assign m_axis_tuser  = {out_result.alarm, out_result.refresh};

endmodule
